@@ rtl/calu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package calu_pkg;

  // operation codes
  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_ADC   = 4'd1;
  localparam logic [3:0] OP_SUB   = 4'd2;
  localparam logic [3:0] OP_SBC   = 4'd3;
  localparam logic [3:0] OP_AND   = 4'd4;
  localparam logic [3:0] OP_XOR   = 4'd5;
  localparam logic [3:0] OP_OR    = 4'd6;
  localparam logic [3:0] OP_CP    = 4'd7;
  localparam logic [3:0] OP_INC   = 4'd8;
  localparam logic [3:0] OP_DEC   = 4'd9;
  localparam logic [3:0] OP_DAA   = 4'd10;
  localparam logic [3:0] OP_CPL   = 4'd11;
  localparam logic [3:0] OP_ADD16 = 4'd12;
  localparam logic [3:0] OP_ADDSP = 4'd13;
  localparam logic [3:0] OP_INC16 = 4'd14;
  localparam logic [3:0] OP_DEC16 = 4'd15;

  // decimal adjust constants
  localparam logic [7:0] DAA_LO_ADJ = 8'h06;
  localparam logic [7:0] DAA_HI_ADJ = 8'h60;
  localparam logic [7:0] DAA_HI_MAX = 8'h99;
  localparam logic [3:0] DAA_LO_MAX = 4'd9;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic        zero_in;
    logic        subtract_in;
    logic        half_carry_in;
    logic        carry_in;
  } calu_in_t;

  typedef struct packed {
    logic [15:0] result_value;
    logic        write_result;
    logic        zero_out;
    logic        subtract_out;
    logic        half_carry_out;
    logic        carry_out;
  } calu_out_t;

endpackage

`default_nettype wire

@@ rtl/calu_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// operand channel
interface calu_in_if;
  import calu_pkg::*;

  logic     valid;
  logic     ready;
  calu_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// result channel
interface calu_out_if;
  import calu_pkg::*;

  logic      valid;
  logic      ready;
  calu_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/calu_exec.sv @@
`timescale 1ns / 1ps
`default_nettype none

module calu_exec (
  input  calu_pkg::calu_in_t  op_i,
  output calu_pkg::calu_out_t res_o
);
  import calu_pkg::*;

  logic [7:0]  a;
  logic [7:0]  b;
  logic        k;
  logic [8:0]  add9;
  logic [4:0]  addh5;
  logic [8:0]  sub9;
  logic [4:0]  subh5;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic        daa_lo;
  logic        daa_hi;
  logic [7:0]  daa_up;
  logic [7:0]  daa_dn;
  logic [7:0]  daa_r;
  logic [16:0] sum17;
  logic [12:0] sumh13;
  logic [15:0] sp_ext;
  logic [15:0] sp_sum;
  logic [4:0]  sph5;
  logic [8:0]  spc9;

  assign a = op_i.operand_a[7:0];
  assign b = op_i.operand_b[7:0];

  // carry in only for the with-carry forms
  assign k = op_i.carry_in & ((op_i.opcode == OP_ADC) || (op_i.opcode == OP_SBC));

  // 8-bit add and subtract with nibble carries
  assign add9  = {1'b0, a} + {1'b0, b} + {8'd0, k};
  assign addh5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, k};
  assign sub9  = {1'b0, a} - {1'b0, b} - {8'd0, k};
  assign subh5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, k};
  assign inc8  = a + 8'd1;
  assign dec8  = a - 8'd1;

  // decimal adjust
  assign daa_lo = op_i.half_carry_in || (a[3:0] > DAA_LO_MAX);
  assign daa_hi = op_i.carry_in || (a > DAA_HI_MAX);
  assign daa_up = a + (daa_hi ? DAA_HI_ADJ : 8'd0) + (daa_lo ? DAA_LO_ADJ : 8'd0);
  assign daa_dn = a - (op_i.carry_in ? DAA_HI_ADJ : 8'd0)
                    - (op_i.half_carry_in ? DAA_LO_ADJ : 8'd0);
  assign daa_r  = op_i.subtract_in ? daa_dn : daa_up;

  // 16-bit add, carry from bit 11 and bit 15
  assign sum17  = {1'b0, op_i.operand_a} + {1'b0, op_i.operand_b};
  assign sumh13 = {1'b0, op_i.operand_a[11:0]} + {1'b0, op_i.operand_b[11:0]};

  // stack pointer plus signed byte, flags from the low byte
  assign sp_ext = {{8{b[7]}}, b};
  assign sp_sum = op_i.operand_a + sp_ext;
  assign sph5   = {1'b0, op_i.operand_a[3:0]} + {1'b0, b[3:0]};
  assign spc9   = {1'b0, op_i.operand_a[7:0]} + {1'b0, b};

  // result and flag select
  always_comb begin
    res_o.result_value   = 16'd0;
    res_o.write_result   = 1'b1;
    res_o.zero_out       = op_i.zero_in;
    res_o.subtract_out   = op_i.subtract_in;
    res_o.half_carry_out = op_i.half_carry_in;
    res_o.carry_out      = op_i.carry_in;
    case (op_i.opcode)
      OP_ADD, OP_ADC: begin
        res_o.result_value   = {8'd0, add9[7:0]};
        res_o.zero_out       = (add9[7:0] == 8'd0);
        res_o.subtract_out   = 1'b0;
        res_o.half_carry_out = addh5[4];
        res_o.carry_out      = add9[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        res_o.result_value   = {8'd0, sub9[7:0]};
        res_o.write_result   = (op_i.opcode != OP_CP);
        res_o.zero_out       = (sub9[7:0] == 8'd0);
        res_o.subtract_out   = 1'b1;
        res_o.half_carry_out = subh5[4];
        res_o.carry_out      = sub9[8];
      end
      OP_AND: begin
        res_o.result_value   = {8'd0, a & b};
        res_o.zero_out       = ((a & b) == 8'd0);
        res_o.subtract_out   = 1'b0;
        res_o.half_carry_out = 1'b1;
        res_o.carry_out      = 1'b0;
      end
      OP_XOR: begin
        res_o.result_value   = {8'd0, a ^ b};
        res_o.zero_out       = ((a ^ b) == 8'd0);
        res_o.subtract_out   = 1'b0;
        res_o.half_carry_out = 1'b0;
        res_o.carry_out      = 1'b0;
      end
      OP_OR: begin
        res_o.result_value   = {8'd0, a | b};
        res_o.zero_out       = ((a | b) == 8'd0);
        res_o.subtract_out   = 1'b0;
        res_o.half_carry_out = 1'b0;
        res_o.carry_out      = 1'b0;
      end
      OP_INC: begin
        res_o.result_value   = {8'd0, inc8};
        res_o.zero_out       = (inc8 == 8'd0);
        res_o.subtract_out   = 1'b0;
        res_o.half_carry_out = (inc8[3:0] == 4'h0);
      end
      OP_DEC: begin
        res_o.result_value   = {8'd0, dec8};
        res_o.zero_out       = (dec8 == 8'd0);
        res_o.subtract_out   = 1'b1;
        res_o.half_carry_out = (dec8[3:0] == 4'hF);
      end
      OP_DAA: begin
        res_o.result_value   = {8'd0, daa_r};
        res_o.zero_out       = (daa_r == 8'd0);
        res_o.half_carry_out = 1'b0;
        res_o.carry_out      = op_i.subtract_in ? op_i.carry_in : daa_hi;
      end
      OP_CPL: begin
        res_o.result_value   = {8'd0, ~a};
        res_o.subtract_out   = 1'b1;
        res_o.half_carry_out = 1'b1;
      end
      OP_ADD16: begin
        res_o.result_value   = sum17[15:0];
        res_o.subtract_out   = 1'b0;
        res_o.half_carry_out = sumh13[12];
        res_o.carry_out      = sum17[16];
      end
      OP_ADDSP: begin
        res_o.result_value   = sp_sum;
        res_o.zero_out       = 1'b0;
        res_o.subtract_out   = 1'b0;
        res_o.half_carry_out = sph5[4];
        res_o.carry_out      = spc9[8];
      end
      OP_INC16: begin
        res_o.result_value = op_i.operand_a + 16'd1;
      end
      OP_DEC16: begin
        res_o.result_value = op_i.operand_a - 16'd1;
      end
      default: begin
        res_o.result_value = 16'd0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/cpu_alu_with_flags.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   dir   handshake      payload
// in_ch     in    valid/ready    opcode, operand_a, operand_b, four flags
// out_ch    out   valid/ready    result_value, write_result, four flags
//
// one item per cycle sustained while out_ch.ready is high; an accepted item passes
// through the operand register, then the flag/result mux into the result register,
// which drives out_ch.valid for its result handshake
// rst_n is synchronous and clears both valid bits, payload is not reset
// in_ch.ready follows out_ch.ready in the same cycle once both the operand and result
// registers hold items; an empty operand register still takes one more item under a stall

module cpu_alu_with_flags (
  input  wire        clk,
  input  wire        rst_n,
  calu_in_if.sink    in_ch,
  calu_out_if.source out_ch
);
  import calu_pkg::*;

  logic      in_v_r;
  logic      in_v_nxt;
  calu_in_t  in_d_r;
  logic      out_v_r;
  logic      out_v_nxt;
  calu_out_t out_d_r;
  calu_out_t exec_res;
  logic      stage_adv;
  logic      in_take;

  // handshake control
  assign stage_adv   = !out_v_r || out_ch.ready;
  assign in_ch.ready = !in_v_r || stage_adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  assign in_v_nxt  = in_ch.ready ? in_ch.valid : in_v_r;
  assign out_v_nxt = stage_adv ? in_v_r : out_v_r;

  // operand register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_d_r <= in_ch.data;
    end
  end

  calu_exec u_exec (
    .op_i  (in_d_r),
    .res_o (exec_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv && in_v_r) begin
      out_d_r <= exec_res;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_d_r;

`ifndef SYNTH
  // an accepted item is held in the operand register next cycle
  a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> in_v_r)
    else $error("accepted item not captured");

  // a blocked operand register keeps its item
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !stage_adv |=> in_v_r && $stable(in_d_r))
    else $error("operand register lost item under stall");

  // 8-bit operations leave the upper byte clear
  a_byte_ops: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && (in_d_r.opcode < OP_ADD16) |-> exec_res.result_value[15:8] == 8'd0)
    else $error("upper byte set on 8-bit operation");

  // compare suppresses write and behaves as subtract
  a_cp_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && (in_d_r.opcode == OP_CP) |-> !exec_res.write_result && exec_res.subtract_out)
    else $error("compare wrote result or cleared subtract flag");
`endif

endmodule

`default_nettype wire
